// ----- design/wbsm_pkg.sv -----
package wbsm_pkg;

    // Elements the expected-byte words can hold
    localparam int ELEMENT_STORE = 32;
    localparam int MAX_PATTERN_LEN_DEFAULT = 32;

    localparam int BYTE_W = 8;
    localparam int POS_W = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int LEN_W = 6;
    localparam int VALUE_WORDS = 4;
    localparam int BYTES_PER_WORD = 8;

    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_VALUE_WORD_0   = 3'd0,
        REG_VALUE_WORD_1   = 3'd1,
        REG_VALUE_WORD_2   = 3'd2,
        REG_VALUE_WORD_3   = 3'd3,
        REG_NIBBLE_CARE    = 3'd4,
        REG_PATTERN_LENGTH = 3'd5
    } reg_index_t;

    // Per-element compare of one byte against its expected value and care code
    function automatic logic element_hit(
        input logic [BYTE_W-1:0] data_byte,
        input logic [BYTE_W-1:0] expect_byte,
        input logic [1:0]        care_code
    );
        logic [BYTE_W-1:0] care;
        care = {(care_code[1] ? NIBBLE_MASK : 4'h0), (care_code[0] ? NIBBLE_MASK : 4'h0)};
        return ((data_byte ^ expect_byte) & care) == '0;
    endfunction

endpackage

// ----- design/wbsm_byte_if.sv -----
interface wbsm_byte_if;
    logic                          valid;
    logic                          ready;
    logic [wbsm_pkg::BYTE_W-1:0]   byte_value;
    logic                          end_of_chunk;

    modport source (output valid, output byte_value, output end_of_chunk, input ready);
    modport sink   (input valid, input byte_value, input end_of_chunk, output ready);
endinterface

// ----- design/wbsm_match_if.sv -----
interface wbsm_match_if;
    logic                        valid;
    logic                        ready;
    logic [wbsm_pkg::POS_W-1:0]  match_start_position;
    logic [wbsm_pkg::POS_W-1:0]  match_end_position;

    modport source (output valid, output match_start_position, output match_end_position,
                    input ready);
    modport sink   (input valid, input match_start_position, input match_end_position,
                    output ready);
endinterface

// ----- design/wbsm_cfg_if.sv -----
interface wbsm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [wbsm_pkg::CFG_INDEX_W-1:0]  index;
    logic [wbsm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/wildcard_byte_signature_matcher_unit.sv -----
// Wildcard byte signature matcher.
// A match passes the input register and then the output register to match_out.
// Throughput: one byte per cycle unless match_out stalls; prefix_reg feeds back.
// Reset (rst_n low, async): prefix vector and byte position clear, config goes to
// all-zero words with length 1, and no word is held in either stage.
module wildcard_byte_signature_matcher_unit #(
    parameter int MAX_PATTERN_LEN = wbsm_pkg::MAX_PATTERN_LEN_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    wbsm_byte_if.sink            byte_in,
    wbsm_match_if.source         match_out,
    wbsm_cfg_if.sink             cfg
);

    // Usable elements: the parameter, capped by what the value words hold
    localparam int NumElem = (MAX_PATTERN_LEN > wbsm_pkg::ELEMENT_STORE)
                             ? wbsm_pkg::ELEMENT_STORE
                             : ((MAX_PATTERN_LEN < 1) ? 1 : MAX_PATTERN_LEN);
    localparam int LenW = wbsm_pkg::LEN_W;
    localparam int PosW = wbsm_pkg::POS_W;
    localparam logic [LenW-1:0] LenMax = LenW'(NumElem);
    localparam logic [LenW-1:0] LenOne = LenW'(1);

    // ------------------------------------------------------------------
    // Configuration registers; writes always accepted
    // ------------------------------------------------------------------
    logic [wbsm_pkg::CFG_DATA_W-1:0] value_word_reg [wbsm_pkg::VALUE_WORDS];
    logic [wbsm_pkg::CFG_DATA_W-1:0] nibble_care_reg;
    logic [LenW-1:0]                 pattern_length_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < wbsm_pkg::VALUE_WORDS; w++)
            begin
                value_word_reg[w] <= '0;
            end
            nibble_care_reg    <= '0;
            pattern_length_reg <= LenOne;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                wbsm_pkg::REG_VALUE_WORD_0:   value_word_reg[0] <= cfg.data;
                wbsm_pkg::REG_VALUE_WORD_1:   value_word_reg[1] <= cfg.data;
                wbsm_pkg::REG_VALUE_WORD_2:   value_word_reg[2] <= cfg.data;
                wbsm_pkg::REG_VALUE_WORD_3:   value_word_reg[3] <= cfg.data;
                wbsm_pkg::REG_NIBBLE_CARE:    nibble_care_reg   <= cfg.data;
                wbsm_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= cfg.data[LenW-1:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // Effective length: zero reads as one, clamp to the element count
    logic [LenW-1:0] len_eff;
    always_comb
    begin
        if (pattern_length_reg == '0)
            len_eff = LenOne;
        else if (pattern_length_reg > LenMax)
            len_eff = LenMax;
        else
            len_eff = pattern_length_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register -> match logic -> output register
    // ------------------------------------------------------------------
    logic                         in_valid_reg;
    logic [wbsm_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [PosW-1:0]              out_start_reg;
    logic [PosW-1:0]              out_end_reg;
    logic                         advance;
    logic                         step;

    // Output stage frees up when empty or being drained this cycle
    assign advance      = !out_valid_reg || match_out.ready;
    assign byte_in.ready = !in_valid_reg || advance;
    assign step         = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    // end_of_chunk carries no meaning here: matching spans chunk boundaries
    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            in_byte_reg <= byte_in.byte_value;
        end
    end

    // ------------------------------------------------------------------
    // Bit-parallel match: shift-and of the active prefix vector
    // ------------------------------------------------------------------
    logic [NumElem-1:0] prefix_reg;
    logic [NumElem-1:0] prefix_next;
    logic [NumElem-1:0] hits;
    logic [NumElem-1:0] len_mask;
    logic [NumElem-1:0] last_sel;
    logic [NumElem-1:0] shifted;
    logic [PosW-1:0]    pos_reg;
    logic [PosW-1:0]    match_start;
    logic               match_hit;

    for (genvar i = 0; i < NumElem; i++)
    begin : g_elem
        localparam int Word = i / wbsm_pkg::BYTES_PER_WORD;
        localparam int Lane = i % wbsm_pkg::BYTES_PER_WORD;
        assign hits[i] = wbsm_pkg::element_hit(
            in_byte_reg,
            value_word_reg[Word][Lane*wbsm_pkg::BYTE_W +: wbsm_pkg::BYTE_W],
            nibble_care_reg[2*i +: 2]);
        assign len_mask[i] = (LenW'(i) < len_eff);
        assign last_sel[i] = (LenW'(i + 1) == len_eff);
    end

    if (NumElem > 1)
    begin : g_shift
        assign shifted = {prefix_reg[NumElem-2:0], 1'b1};
    end
    else
    begin : g_noshift
        assign shifted = 1'b1;
    end

    assign prefix_next = shifted & hits & len_mask;
    assign match_hit   = |(prefix_next & last_sel);
    // start = end - (len - 1), modulo 2^32
    assign match_start = pos_reg - PosW'(len_eff) + PosW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            pos_reg    <= '0;
        end
        else if (step)
        begin
            prefix_reg <= prefix_next;
            pos_reg    <= pos_reg + PosW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = step && match_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && match_hit)
        begin
            out_start_reg <= match_start;
            out_end_reg   <= pos_reg;
        end
    end

    assign match_out.valid                = out_valid_reg;
    assign match_out.match_start_position = out_start_reg;
    assign match_out.match_end_position   = out_end_reg;

endmodule

// ----- tb/match_position_checker.sv -----
`timescale 1ns / 1ps

// Follows the configuration and byte words, predicts each match span and compares it
// with the spans that leave the block, in order.
module match_position_checker #(
    parameter int MAX_LEN = wbsm_pkg::MAX_PATTERN_LEN_DEFAULT
) (
    input  logic   clk,
    input  logic   rst_n,
    wbsm_byte_if   byte_mon,
    wbsm_match_if  match_mon,
    wbsm_cfg_if    cfg_mon,
    output int     mismatch_count,
    output int     matches_pending
);
    import wbsm_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] end_pos;
    } match_span_t;

    localparam int LEN_LIMIT = (MAX_LEN > ELEMENT_STORE) ? ELEMENT_STORE :
                               (MAX_LEN < 1) ? 1 : MAX_LEN;

    logic [CFG_DATA_W-1:0]    expect_word [VALUE_WORDS];
    logic [CFG_DATA_W-1:0]    care_mask;
    logic [LEN_W-1:0]         length_reg;
    logic [ELEMENT_STORE-1:0] prefix_vec;
    logic [POS_W-1:0]         next_pos;
    match_span_t              expected_matches [$];

    // zero counts as one element, anything past the store is clipped
    function automatic int active_length(input logic [LEN_W-1:0] raw);
        int n;
        n = (raw == '0) ? 1 : int'(raw);
        return (n > LEN_LIMIT) ? LEN_LIMIT : n;
    endfunction

    // bit i set when element i accepts the byte
    function automatic logic [ELEMENT_STORE-1:0] element_hits(input logic [BYTE_W-1:0] b);
        logic [ELEMENT_STORE-1:0] hits;
        logic [BYTE_W-1:0]        want;
        logic [BYTE_W-1:0]        diff;
        logic [1:0]               code;
        for (int i = 0; i < ELEMENT_STORE; i++)
        begin
            want = expect_word[i / BYTES_PER_WORD][(i % BYTES_PER_WORD) * BYTE_W +: BYTE_W];
            code = care_mask[2 * i +: 2];
            diff = b ^ want;
            hits[i] = !((code[0] && diff[3:0] != '0) || (code[1] && diff[7:4] != '0));
        end
        return hits;
    endfunction

    task automatic store_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_VALUE_WORD_0:   expect_word[0] = val;
            REG_VALUE_WORD_1:   expect_word[1] = val;
            REG_VALUE_WORD_2:   expect_word[2] = val;
            REG_VALUE_WORD_3:   expect_word[3] = val;
            REG_NIBBLE_CARE:    care_mask = val;
            REG_PATTERN_LENGTH: length_reg = val[LEN_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic scan_byte(input logic [BYTE_W-1:0] b);
        int                       len;
        logic [ELEMENT_STORE-1:0] len_mask;
        match_span_t              span;
        len = active_length(length_reg);
        len_mask = {ELEMENT_STORE{1'b1}} >> (ELEMENT_STORE - len);
        prefix_vec = {prefix_vec[ELEMENT_STORE-2:0], 1'b1} & element_hits(b) & len_mask;
        if (prefix_vec[len-1])
        begin
            span.start_pos = next_pos - POS_W'(len - 1);
            span.end_pos = next_pos;
            expected_matches = {expected_matches, span};
        end
        next_pos = next_pos + 1'b1;
    endtask

    task automatic check_match(input logic [POS_W-1:0] got_start,
                               input logic [POS_W-1:0] got_end);
        match_span_t span;
        if (expected_matches.size() == 0)
        begin
            $error("match with nothing predicted: start %0d end %0d", got_start, got_end);
            mismatch_count++;
        end
        else
        begin
            span = expected_matches.pop_front();
            if (got_start !== span.start_pos)
            begin
                $error("match_start_position: expected %0d, got %0d", span.start_pos, got_start);
                mismatch_count++;
            end
            if (got_end !== span.end_pos)
            begin
                $error("match_end_position: expected %0d, got %0d", span.end_pos, got_end);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < VALUE_WORDS; w++)
            begin
                expect_word[w] = '0;
            end
            care_mask = '0;
            length_reg = LEN_W'(1);
            prefix_vec = '0;
            next_pos = '0;
            expected_matches.delete();
            matches_pending = 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                store_register(cfg_mon.index, cfg_mon.data);
            end
            if (match_mon.valid && match_mon.ready)
            begin
                check_match(match_mon.match_start_position, match_mon.match_end_position);
            end
            if (byte_mon.valid && byte_mon.ready)
            begin
                scan_byte(byte_mon.byte_value);
            end
            matches_pending = expected_matches.size();
        end
    end

endmodule

// ----- tb/tb_wildcard_byte_signature_matcher_unit.sv -----
`timescale 1ns / 1ps

// Top of the matcher bench: drives bytes and register writes, stalls the match
// receiver, and gives the verdict from the checker's mismatch and pending counts.
module tb_wildcard_byte_signature_matcher_unit;
    import wbsm_pkg::*;

    // Indexes past the last register; writes there must leave everything alone.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam int SEGMENTS          = 8;
    localparam int ITEMS_PER_SEGMENT = 166;
    // Match crosses the input and output registers after its last byte; add slack.
    localparam int DRAIN_CYCLES      = 6;
    // Cycles with no word moving on any channel before the run is declared hung.
    localparam int STALL_LIMIT       = 2000;

    logic clk = 1'b0;
    logic rst_n;

    wbsm_byte_if  byte_in ();
    wbsm_match_if match_out ();
    wbsm_cfg_if   cfg ();

    int mismatch_count;
    int matches_pending;
    int src_idle_pct;
    int snk_stall_pct;
    int quiet_cycles;

    // Bench-side copy of the signature, used only to build matching byte runs.
    logic [CFG_DATA_W-1:0] sig_word [VALUE_WORDS];
    logic [CFG_DATA_W-1:0] sig_care;
    logic [LEN_W-1:0]      sig_len_raw;

    wildcard_byte_signature_matcher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .match_out (match_out),
        .cfg       (cfg)
    );

    match_position_checker #(
        .MAX_LEN (MAX_PATTERN_LEN_DEFAULT)
    ) position_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_mon        (byte_in),
        .match_mon       (match_out),
        .cfg_mon         (cfg),
        .mismatch_count  (mismatch_count),
        .matches_pending (matches_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random backpressure on the match channel, set per phase.
    always @(negedge clk)
    begin
        match_out.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Watchdog: only cycles where nothing at all is accepted count toward the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (byte_in.valid && byte_in.ready) || (cfg.valid && cfg.ready)
            || (match_out.valid && match_out.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Length the block will actually use: zero means one, past the store is clipped.
    function automatic int signature_length();
        if (sig_len_raw == '0)
        begin
            return 1;
        end
        return (int'(sig_len_raw) > ELEMENT_STORE) ? ELEMENT_STORE : int'(sig_len_raw);
    endfunction

    // A byte that element i accepts; with spoil set, one cared bit is flipped so it
    // fails. An element that matches any byte cannot be spoiled.
    function automatic logic [BYTE_W-1:0] element_byte(input int i, input bit spoil);
        logic [BYTE_W-1:0] want;
        logic [BYTE_W-1:0] b;
        logic [1:0]        code;
        want = sig_word[i / BYTES_PER_WORD][(i % BYTES_PER_WORD) * BYTE_W +: BYTE_W];
        code = sig_care[2 * i +: 2];
        b = BYTE_W'($urandom);
        if (code[0])
        begin
            b[3:0] = want[3:0];
        end
        if (code[1])
        begin
            b[7:4] = want[7:4];
        end
        if (spoil && code != 2'b00)
        begin
            b ^= 8'd1 << ((code == 2'b11) ? $urandom_range(7) :
                          code[1] ? 4 + $urandom_range(3) : $urandom_range(3));
        end
        return b;
    endfunction

    // One byte word; the source may sit idle at random first. Valid stays
    // high after acceptance so back-to-back words need no extra edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eoc);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_in.valid <= 1'b0;
            @(negedge clk);
        end
        byte_in.valid <= 1'b1;
        byte_in.byte_value <= b;
        byte_in.end_of_chunk <= eoc;
        do @(posedge clk); while (!byte_in.ready);
    endtask

    task automatic idle_source();
        @(negedge clk);
        byte_in.valid <= 1'b0;
    endtask

    // Hold off until every predicted match has come out, then let any byte that
    // matches nothing clear the pipeline.
    task automatic settle_block();
        while (matches_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            REG_VALUE_WORD_0:   sig_word[0] = val;
            REG_VALUE_WORD_1:   sig_word[1] = val;
            REG_VALUE_WORD_2:   sig_word[2] = val;
            REG_VALUE_WORD_3:   sig_word[3] = val;
            REG_NIBBLE_CARE:    sig_care = val;
            REG_PATTERN_LENGTH: sig_len_raw = val[LEN_W-1:0];
            default:            ;
        endcase
    endtask

    // Elements 0..upto-1 of the signature in order; spoil_at names the element
    // that is made to fail (out of range for a clean run).
    task automatic send_signature(input int spoil_at, input int upto);
        for (int i = 0; i < upto; i++)
        begin
            send_byte(element_byte(i, i == spoil_at), $urandom_range(7) == 0);
        end
    endtask

    initial
    begin
        int seg;
        int sent;
        int pick;
        int n;
        int spoil_at;
        int burst;

        // every input known from time zero; the receiver drives ready itself
        rst_n = 1'b0;
        byte_in.valid = 1'b0;
        byte_in.byte_value = '0;
        byte_in.end_of_chunk = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        for (int w = 0; w < VALUE_WORDS; w++)
        begin
            sig_word[w] = '0;
        end
        sig_care = '0;
        sig_len_raw = LEN_W'(1);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        // Reset config is one element that takes any byte: every word is a match,
        // including the byte extremes and an end-of-chunk mark.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h5A, 1'b0);
        idle_source();
        settle_block();

        // Four elements, one per compare kind: full A5, high nibble 3, low nibble 7,
        // then any byte.
        write_reg(REG_VALUE_WORD_0, 64'hFFFF_FFFF_FF37_3CA5);
        write_reg(REG_NIBBLE_CARE, 64'h0000_0000_0000_001B);
        write_reg(REG_PATTERN_LENGTH, 64'd4);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'h99, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'h00, 1'b0);
        // near misses: low nibble of the full byte, then both nibble-only elements
        send_byte(8'hA4, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'h99, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h4F, 1'b0);
        send_byte(8'h06, 1'b0);
        // Partial prefix, then shorten the signature: the live prefix survives the
        // write, so the next byte completes a three-element match.
        send_byte(8'hA5, 1'b0);
        send_byte(8'h3F, 1'b1);
        idle_source();
        settle_block();
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        send_byte(8'h07, 1'b0);
        idle_source();
        settle_block();

        // Length zero behaves as one element; writes past the last register are dropped.
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        write_reg(REG_SPARE_6, '0);
        write_reg(REG_SPARE_7, '1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hA4, 1'b0);

        // --- random part ---
        // Two segments per idling phase, each with its own signature. Register
        // extremes land in segments 0 to 4; the last two use short signatures so
        // matches stay frequent.
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 77;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    snk_stall_pct = 77;
                end
                default:
                begin
                    src_idle_pct = 8;
                    snk_stall_pct = 8;
                end
            endcase

            // the pause before each config change also drains every pending match
            idle_source();
            settle_block();

            for (int w = 0; w < VALUE_WORDS; w++)
            begin
                case (seg)
                    1:       write_reg(CFG_INDEX_W'(REG_VALUE_WORD_0 + w), '1);
                    2:       write_reg(CFG_INDEX_W'(REG_VALUE_WORD_0 + w), '0);
                    default: write_reg(CFG_INDEX_W'(REG_VALUE_WORD_0 + w),
                                       {$urandom, $urandom});
                endcase
            end
            case (seg)
                0, 1:    write_reg(REG_NIBBLE_CARE, '1);
                2:       write_reg(REG_NIBBLE_CARE, '0);
                default: write_reg(REG_NIBBLE_CARE, {$urandom, $urandom});
            endcase
            case (seg)
                0:       write_reg(REG_PATTERN_LENGTH, 64'd32);
                1:       write_reg(REG_PATTERN_LENGTH, 64'd63);
                2:       write_reg(REG_PATTERN_LENGTH, 64'd1);
                3:       write_reg(REG_PATTERN_LENGTH, 64'd0);
                4:       write_reg(REG_PATTERN_LENGTH, 64'd33);
                5:       write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(9, 31)));
                default: write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(2, 8)));
            endcase
            if (seg == 3)
            begin
                write_reg(REG_SPARE_6, {$urandom, $urandom});
                write_reg(REG_SPARE_7, {$urandom, $urandom});
            end

            // Mostly clean signatures with random don't-care bits, some broken
            // ones (one element spoiled, possibly cut short), and plain noise.
            n = signature_length();
            sent = 0;
            while (sent < ITEMS_PER_SEGMENT)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    send_signature(n, n);
                    sent += n;
                end
                else if (pick < 75)
                begin
                    spoil_at = $urandom_range(n - 1);
                    burst = $urandom_range(spoil_at + 1, n);
                    send_signature(spoil_at, burst);
                    sent += burst;
                end
                else
                begin
                    burst = $urandom_range(1, 6);
                    for (int k = 0; k < burst; k++)
                    begin
                        send_byte(BYTE_W'($urandom), $urandom_range(7) == 0);
                    end
                    sent += burst;
                end
            end
        end

        idle_source();
        settle_block();

        if (mismatch_count == 0 && matches_pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/wbsm_pkg.sv
design/wbsm_byte_if.sv
design/wbsm_match_if.sv
design/wbsm_cfg_if.sv
design/wildcard_byte_signature_matcher_unit.sv
tb/match_position_checker.sv
tb/tb_wildcard_byte_signature_matcher_unit.sv
